### sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the selection sort table
// Holds the record capacity, index widths and the request structs of both
// channels.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Capacity of the record store.
  localparam int unsigned MaxEntries = 16;

  // Index width addresses one entry; count width also holds the full count.
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  localparam int unsigned KeyW = 9;
  localparam int unsigned PayloadW = 9;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // One stored record.
  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } rec_t;

  // Input request.
  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    logic                last_in;
  } in_req_t;

  // Output request.
  typedef struct packed {
    logic [KeyW-1:0]     sorted_key;
    logic [PayloadW-1:0] sorted_payload;
    logic                last_out;
    logic                overflow;
  } out_req_t;

endpackage

### sv/selection_sort_table.sv
// ----------------------------------------------------------------------------
// selection_sort_table: collects records and releases them sorted by key
// Input requests are taken only while a set is being loaded; the input is
// stalled while a set is sorted and released. Sorting is a selection sort
// with a single key comparator and the single read port of the record store.
// Each sorted record is then read from the store and offered until taken.
// Reset clears the count, the overflow flag and the sequencer; the store
// itself is not cleared.
// ----------------------------------------------------------------------------
module selection_sort_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sst_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sst_pkg::out_req_t out_req_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDPOS  = 7'b0000010,
    S_POS    = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_WR1    = 7'b0010000,
    S_WR2    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  // In S_EMIT the read is issued while show_q is low; show_q high marks the
  // cycles that offer the record just read.
  state_e state_q, state_d;
  logic   show_q, show_d;

  sst_pkg::cnt_t cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  sst_pkg::idx_t pos_q, pos_d;
  sst_pkg::idx_t scan_q, scan_d;
  sst_pkg::idx_t best_idx_q, best_idx_d;
  sst_pkg::idx_t out_idx_q, out_idx_d;
  sst_pkg::rec_t pos_rec_q, pos_rec_d;
  sst_pkg::rec_t best_rec_q, best_rec_d;

  // Record store with one write port and one registered read port.
  sst_pkg::rec_t store_mem [sst_pkg::MaxEntries];
  sst_pkg::rec_t rd_q;
  logic          wr_en, rd_en;
  sst_pkg::idx_t wr_addr, rd_addr;
  sst_pkg::rec_t wr_data;

  logic in_acc, out_acc;
  logic is_less;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // The single comparator: freshly read key against the best key so far.
  assign is_less = rd_q.key < best_rec_q.key;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT) && show_q;

  // The sorted key and payload come straight from the read register, which
  // holds while the output is stalled.
  always_comb begin
    out_req_o.sorted_key     = rd_q.key;
    out_req_o.sorted_payload = rd_q.payload;
    out_req_o.last_out       = (sst_pkg::CntW'(out_idx_q) + sst_pkg::CntW'(1)) == cnt_q;
    out_req_o.overflow       = ovf_q;
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    show_d     = show_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    scan_d     = scan_q;
    best_idx_d = best_idx_q;
    out_idx_d  = out_idx_q;
    pos_rec_d  = pos_rec_q;
    best_rec_d = best_rec_q;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = best_rec_q;
    rd_en      = 1'b0;
    rd_addr    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < sst_pkg::CntW'(sst_pkg::MaxEntries)) begin
            wr_en           = 1'b1;
            wr_addr         = sst_pkg::IdxW'(cnt_q);
            wr_data.key     = in_req_i.key;
            wr_data.payload = in_req_i.payload;
            cnt_d           = cnt_q + sst_pkg::CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_req_i.last_in) begin
            pos_d     = '0;
            out_idx_d = '0;
            show_d    = 1'b0;
            // A single record needs no sorting.
            if (cnt_d >= sst_pkg::CntW'(2)) begin
              state_d = S_RDPOS;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_RDPOS: begin
        rd_en   = 1'b1;
        rd_addr = pos_q;
        state_d = S_POS;
      end

      // The record at the current position seeds the minimum search.
      S_POS: begin
        pos_rec_d  = rd_q;
        best_rec_d = rd_q;
        best_idx_d = pos_q;
        rd_en      = 1'b1;
        rd_addr    = pos_q + sst_pkg::IdxW'(1);
        scan_d     = pos_q + sst_pkg::IdxW'(1);
        state_d    = S_SCAN;
      end

      // One candidate per cycle; only a strictly smaller key replaces it.
      S_SCAN: begin
        if (is_less) begin
          best_rec_d = rd_q;
          best_idx_d = scan_q;
        end
        if ((sst_pkg::CntW'(scan_q) + sst_pkg::CntW'(1)) < cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = scan_q + sst_pkg::IdxW'(1);
          scan_d  = scan_q + sst_pkg::IdxW'(1);
        end else begin
          state_d = S_WR1;
        end
      end

      // Swap, first half: the minimum goes to the current position.
      S_WR1: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = best_rec_q;
        state_d = S_WR2;
      end

      // Swap, second half: the displaced record goes where the minimum was.
      S_WR2: begin
        wr_en   = 1'b1;
        wr_addr = best_idx_q;
        wr_data = pos_rec_q;
        pos_d   = pos_q + sst_pkg::IdxW'(1);
        if ((sst_pkg::CntW'(pos_q) + sst_pkg::CntW'(2)) < cnt_q) begin
          state_d = S_RDPOS;
        end else begin
          show_d  = 1'b0;
          state_d = S_EMIT;
        end
      end

      // Read one sorted record, then offer it until it is taken.
      S_EMIT: begin
        if (!show_q) begin
          rd_en   = 1'b1;
          rd_addr = out_idx_q;
          show_d  = 1'b1;
        end else if (out_acc) begin
          show_d = 1'b0;
          if (out_req_o.last_out) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            out_idx_d = out_idx_q + sst_pkg::IdxW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      show_q  <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      show_q  <= show_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // Index and record registers carry data only.
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    scan_q     <= scan_d;
    best_idx_q <= best_idx_d;
    out_idx_q  <= out_idx_d;
    pos_rec_q  <= pos_rec_d;
    best_rec_q <= best_rec_d;
  end

  // Record store write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // The count never exceeds the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sst_pkg::CntW'(sst_pkg::MaxEntries))
    else $error("record count exceeds capacity");

  // No input is taken while a sorted record is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while output is valid");

  // The minimum search never looks behind the current position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q > pos_q) && (best_idx_q >= pos_q))
    else $error("minimum search index behind current position");

  // Taking the final sorted record reopens the input with an empty set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_req_o.last_out) |=> (!in_stall_o && (cnt_q == '0) && !ovf_q))
    else $error("set not cleared after the final record");

  // A dropped record can only have happened with a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> (cnt_q == sst_pkg::CntW'(sst_pkg::MaxEntries)))
    else $error("overflow raised below capacity");

endmodule
